>>> src/tbf_pkg.sv
package tbf_pkg;

	localparam int MAX_N_BLOCKS    = 64;
	localparam int MAX_MASK_BLOCKS = 64;
	localparam int N_IDX_W = (MAX_N_BLOCKS > 1) ? $clog2(MAX_N_BLOCKS) : 1;
	localparam int M_IDX_W = (MAX_MASK_BLOCKS > 1) ? $clog2(MAX_MASK_BLOCKS) : 1;
	localparam int N_CNT_W = $clog2(MAX_N_BLOCKS + 1);
	localparam int M_CNT_W = $clog2(MAX_MASK_BLOCKS + 1);
	localparam int QUEUE_DEPTH = 4;
	localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_N       = 8'h4E;
	localparam logic [7:0] CHAR_NL      = 8'h0A;
	localparam logic [7:0] LOWER_OFFSET = 8'd32;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_LOAD_N = 2'd1,
		OP_LOAD_MASK = 2'd2,
		OP_BYTE = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		REG_LINE_WIDTH = 1'b0,
		REG_SEQ_LENGTH = 1'b1
	} reg_index_t;

	// back end phase: check pointers, emit nucleotide, emit newline
	typedef enum logic [1:0] {
		PH_SKIP,
		PH_CHAR,
		PH_NL
	} phase_t;

	typedef struct packed {
		opcode_t     op;
		logic [31:0] start;
		logic [31:0] stop;
		logic        valid_block;
		logic [7:0]  packed_byte;
	} cmd_t;

	function automatic logic [7:0] base_letter(input logic [1:0] code);
		logic [7:0] r;
		case (code)
			2'd0: r = 8'h54;
			2'd1: r = 8'h43;
			2'd2: r = 8'h41;
			2'd3: r = 8'h47;
			default: r = 8'h54;
		endcase
		return r;
	endfunction

endpackage

>>> src/tbf_if.sv
interface tbf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [31:0] block_start;
	logic [31:0] block_length;
	logic [7:0]  packed_byte;
	modport source (output valid, opcode, block_start, block_length, packed_byte, input ready);
	modport sink (input valid, opcode, block_start, block_length, packed_byte, output ready);
endinterface

interface tbf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] fasta_char;
	logic       last_in_run;
	logic       sequence_end;
	modport source (output valid, fasta_char, last_in_run, sequence_end, input ready);
	modport sink (input valid, fasta_char, last_in_run, sequence_end, output ready);
endinterface

interface tbf_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/tbf_front.sv
module tbf_front
	import tbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] block_start,
	input  logic [31:0] block_length,
	input  logic [7:0]  packed_byte,
	output logic        q_valid,
	input  logic        q_pop,
	output cmd_t        q_head
);
	cmd_t             mem_q [QUEUE_DEPTH];
	logic [Q_IDX_W:0] wr_q, rd_q;
	logic [32:0]      end_sum;
	cmd_t             cmd;
	logic             push;

	always_comb begin
		end_sum = {1'b0, block_start} + {1'b0, block_length} - 33'd1;
		cmd.op = opcode_t'(opcode);
		cmd.start = block_start;
		cmd.stop = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
		cmd.valid_block = (block_length != 32'd0);
		cmd.packed_byte = packed_byte;
	end

	assign in_ready = (wr_q - rd_q) != (Q_IDX_W + 1)'(QUEUE_DEPTH);
	assign push = in_valid && in_ready;
	assign q_valid = wr_q != rd_q;
	assign q_head = mem_q[rd_q[Q_IDX_W-1:0]];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q[Q_IDX_W-1:0]] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
		end
	end
endmodule

>>> src/tbf_back.sv
module tbf_back
	import tbf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] line_width,
	input  logic [31:0] sequence_length,
	input  logic        q_valid,
	output logic        q_pop,
	input  cmd_t        q_head,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  fasta_char,
	output logic        last_in_run,
	output logic        sequence_end
);
	logic [31:0] n_start_mem [MAX_N_BLOCKS];
	logic [31:0] n_end_mem   [MAX_N_BLOCKS];
	logic [31:0] m_start_mem [MAX_MASK_BLOCKS];
	logic [31:0] m_end_mem   [MAX_MASK_BLOCKS];

	// registered read data of the entries under the pointers
	logic [31:0] ns_q, ne_q, ms_q, me_q;

	logic [N_CNT_W-1:0] n_count_q, n_ptr_q, n_count_d, n_ptr_d;
	logic [M_CNT_W-1:0] m_count_q, m_ptr_q, m_count_d, m_ptr_d;
	logic [31:0] pos_q, pos_d;
	logic [15:0] col_q, col_d;
	logic [1:0]  nuc_q, nuc_d;
	phase_t      phase_q, phase_d;
	logic        out_valid_d, last_d, end_d;
	logic [7:0]  char_d;

	logic        n_we, m_we;
	logic        n_adv, m_adv, n_hit, m_hit, in_seq, last_nuc;
	logic        col_full, is_end, out_free;
	logic [1:0]  code;
	logic [7:0]  ch;

	always_comb begin
		n_we = q_valid && q_head.op == OP_LOAD_N && q_head.valid_block
			&& n_count_q < N_CNT_W'(MAX_N_BLOCKS);
		m_we = q_valid && q_head.op == OP_LOAD_MASK && q_head.valid_block
			&& m_count_q < M_CNT_W'(MAX_MASK_BLOCKS);
		n_adv = (n_ptr_q < n_count_q) && (ne_q < pos_q);
		m_adv = (m_ptr_q < m_count_q) && (me_q < pos_q);
		n_hit = (n_ptr_q < n_count_q) && (ns_q <= pos_q);
		m_hit = (m_ptr_q < m_count_q) && (ms_q <= pos_q);
		in_seq = pos_q < sequence_length;
		last_nuc = nuc_q == 2'd3;
		code = q_head.packed_byte[7 - 2*nuc_q -: 2];
		ch = n_hit ? CHAR_N : base_letter(code);
		if (m_hit) ch = ch + LOWER_OFFSET;
		is_end = (pos_q + 32'd1) == sequence_length;
		col_full = ({1'b0, col_q} + 17'd1) >= ((line_width == 16'd0) ? 17'h10000
			: {1'b0, line_width});
		out_free = !out_valid || out_ready;
	end

	// next state, queue pop and output register load
	always_comb begin
		n_count_d = n_count_q;
		m_count_d = m_count_q;
		n_ptr_d = n_ptr_q;
		m_ptr_d = m_ptr_q;
		pos_d = pos_q;
		col_d = col_q;
		nuc_d = nuc_q;
		phase_d = phase_q;
		out_valid_d = out_valid && !out_ready;
		char_d = fasta_char;
		last_d = last_in_run;
		end_d = sequence_end;
		q_pop = 1'b0;
		if (q_valid) begin
			case (q_head.op)
				OP_START: begin
					q_pop = 1'b1;
					n_count_d = '0;
					m_count_d = '0;
					n_ptr_d = '0;
					m_ptr_d = '0;
					pos_d = '0;
					col_d = '0;
				end
				OP_LOAD_N: begin
					q_pop = 1'b1;
					if (n_we) n_count_d = n_count_q + 1'b1;
				end
				OP_LOAD_MASK: begin
					q_pop = 1'b1;
					if (m_we) m_count_d = m_count_q + 1'b1;
				end
				OP_BYTE: begin
					case (phase_q)
						PH_SKIP: begin
							// walk pointers past blocks ending before this position
							if (n_adv) n_ptr_d = n_ptr_q + 1'b1;
							if (m_adv) m_ptr_d = m_ptr_q + 1'b1;
							if (!n_adv && !m_adv) phase_d = PH_CHAR;
						end
						PH_CHAR: begin
							if (!in_seq) begin
								nuc_d = nuc_q + 1'b1;
								phase_d = PH_SKIP;
								q_pop = last_nuc;
							end else if (out_free) begin
								out_valid_d = 1'b1;
								char_d = ch;
								end_d = 1'b0;
								last_d = last_nuc && !(is_end || col_full);
								pos_d = pos_q + 32'd1;
								if (is_end || col_full) begin
									col_d = '0;
									phase_d = PH_NL;
								end else begin
									col_d = col_q + 16'd1;
									nuc_d = nuc_q + 1'b1;
									phase_d = PH_SKIP;
									q_pop = last_nuc;
								end
							end
						end
						PH_NL: if (out_free) begin
							out_valid_d = 1'b1;
							char_d = CHAR_NL;
							end_d = pos_q == sequence_length;
							last_d = last_nuc || (pos_q == sequence_length);
							nuc_d = nuc_q + 1'b1;
							phase_d = PH_SKIP;
							q_pop = last_nuc;
						end
						default: phase_d = PH_SKIP;
					endcase
				end
				default: ;
			endcase
		end
	end

	// block tables; read at the next pointer so the data matches the pointer register
	always_ff @(posedge clk) begin
		if (n_we) begin
			n_start_mem[n_count_q[N_IDX_W-1:0]] <= q_head.start;
			n_end_mem[n_count_q[N_IDX_W-1:0]] <= q_head.stop;
		end
		if (m_we) begin
			m_start_mem[m_count_q[M_IDX_W-1:0]] <= q_head.start;
			m_end_mem[m_count_q[M_IDX_W-1:0]] <= q_head.stop;
		end
		if (n_we && n_count_q == n_ptr_d) begin
			ns_q <= q_head.start;
			ne_q <= q_head.stop;
		end else begin
			ns_q <= n_start_mem[n_ptr_d[N_IDX_W-1:0]];
			ne_q <= n_end_mem[n_ptr_d[N_IDX_W-1:0]];
		end
		if (m_we && m_count_q == m_ptr_d) begin
			ms_q <= q_head.start;
			me_q <= q_head.stop;
		end else begin
			ms_q <= m_start_mem[m_ptr_d[M_IDX_W-1:0]];
			me_q <= m_end_mem[m_ptr_d[M_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_count_q <= '0; m_count_q <= '0; n_ptr_q <= '0; m_ptr_q <= '0;
			pos_q <= '0; col_q <= '0; nuc_q <= '0; phase_q <= PH_SKIP;
			out_valid <= 1'b0; fasta_char <= '0; last_in_run <= 1'b0; sequence_end <= 1'b0;
		end else begin
			n_count_q <= n_count_d; m_count_q <= m_count_d;
			n_ptr_q <= n_ptr_d; m_ptr_q <= m_ptr_d;
			pos_q <= pos_d; col_q <= col_d; nuc_q <= nuc_d; phase_q <= phase_d;
			out_valid <= out_valid_d; fasta_char <= char_d;
			last_in_run <= last_d; sequence_end <= end_d;
		end
	end
endmodule

>>> src/twobit_dna_to_fasta_render_core.sv
// Renders packed 2-bit DNA bytes as FASTA sequence lines, one character per transaction
// on the output channel; no header line is produced. Write line_width (register 0) and
// sequence_length (register 1) only while nothing is in flight, then send a start
// transaction, the N and soft-mask blocks in ascending order, and the packed bytes.
// Input transactions land in a four-entry queue, so the input stays ready while the
// queue has room. Start and block loads retire as they reach the queue head. For each
// nucleotide of a packed byte the back end checks the block pointers, walking them past
// every block that ends before the position, then emits the character, then a newline
// where a line or the sequence ends; it waits while the output stalls. Nucleotides at
// or past the sequence length pass through the same pointer check and emit nothing.
// The last character caused by a byte carries last_in_run; the newline that ends the
// sequence also carries sequence_end.
module twobit_dna_to_fasta_render_core
	import tbf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tbf_in_if.sink   in_ch,
	tbf_out_if.source out_ch,
	tbf_cfg_if.sink  cfg
);
	logic [15:0] line_width_q;
	logic [31:0] seq_len_q;
	logic        q_valid, q_pop;
	cmd_t        q_head;

	assign cfg.ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= 16'd60;
			seq_len_q <= '0;
		end else if (cfg.valid) begin
			case (reg_index_t'(cfg.index))
				REG_LINE_WIDTH: line_width_q <= cfg.data[15:0];
				REG_SEQ_LENGTH: seq_len_q <= cfg.data;
				default: ;
			endcase
		end
	end

	tbf_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.opcode(in_ch.opcode), .block_start(in_ch.block_start),
		.block_length(in_ch.block_length), .packed_byte(in_ch.packed_byte),
		.q_valid, .q_pop, .q_head
	);

	tbf_back u_back (
		.clk, .arst_n,
		.line_width(line_width_q), .sequence_length(seq_len_q),
		.q_valid, .q_pop, .q_head,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.fasta_char(out_ch.fasta_char), .last_in_run(out_ch.last_in_run),
		.sequence_end(out_ch.sequence_end)
	);
endmodule

>>> src/tbf_checker.sv
module tbf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] fasta_char,
	input logic       last_in_run,
	input logic       sequence_end
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fasta_char)) else $error("hold");
	a_end_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_end |-> fasta_char == 8'h0A) else $error("end char");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sequence_end |-> last_in_run) else $error("end last");
endmodule

bind twobit_dna_to_fasta_render_core tbf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.fasta_char(out_ch.fasta_char), .last_in_run(out_ch.last_in_run),
	.sequence_end(out_ch.sequence_end)
);

>>> tb/twobit_dna_to_fasta_render_core_tb.sv
`timescale 1ns / 100ps

module twobit_dna_to_fasta_render_core_tb;
	import tbf_pkg::*;

	typedef struct {
		logic [7:0] fasta_char;
		logic       last_in_run;
		logic       sequence_end;
	} fasta_out_t;

	// Predicts rendered FASTA text and checks every character leaving the core.
	class fasta_scoreboard;
		logic [15:0] line_width = 16'd60;
		logic [31:0] seq_length = 32'd0;
		logic [31:0] position = 32'd0;
		int unsigned column = 0;
		logic [31:0] n_lo [MAX_N_BLOCKS];
		logic [31:0] n_hi [MAX_N_BLOCKS];
		logic [31:0] m_lo [MAX_MASK_BLOCKS];
		logic [31:0] m_hi [MAX_MASK_BLOCKS];
		int n_cnt, m_cnt, n_ptr, m_ptr;
		fasta_out_t pending_chars [$];
		int errors;
		int chars_seen;

		function void write_reg(reg_index_t idx, logic [31:0] value);
			if (idx == REG_LINE_WIDTH)
				line_width = value[15:0];
			else
				seq_length = value;
		endfunction

		function void note_input(opcode_t op, logic [31:0] bs, logic [31:0] bl,
				logic [7:0] pb);
			longint unsigned stop;
			fasta_out_t run [$];
			fasta_out_t c;
			logic [1:0] code;
			logic [7:0] ch;
			int unsigned width;
			stop = longint'(bs) + longint'(bl) - 1;
			if (stop > 64'hFFFF_FFFF)
				stop = 64'hFFFF_FFFF;
			case (op)
				OP_START: begin
					position = 0;
					column = 0;
					n_cnt = 0;
					m_cnt = 0;
					n_ptr = 0;
					m_ptr = 0;
				end
				OP_LOAD_N: begin
					if (bl != 0 && n_cnt < MAX_N_BLOCKS) begin
						n_lo[n_cnt] = bs;
						n_hi[n_cnt] = stop[31:0];
						n_cnt++;
					end
				end
				OP_LOAD_MASK: begin
					if (bl != 0 && m_cnt < MAX_MASK_BLOCKS) begin
						m_lo[m_cnt] = bs;
						m_hi[m_cnt] = stop[31:0];
						m_cnt++;
					end
				end
				default: begin
					for (int i = 0; i < 4; i++) begin
						code = pb[7 - 2 * i -: 2];
						width = (line_width == 0) ? 65536 : line_width;
						if (position >= seq_length)
							continue;
						case (code)
							2'd0: ch = "T";
							2'd1: ch = "C";
							2'd2: ch = "A";
							default: ch = "G";
						endcase
						// skip blocks that end below the current nucleotide
						while (n_ptr < n_cnt && n_hi[n_ptr] < position)
							n_ptr++;
						if (n_ptr < n_cnt && n_lo[n_ptr] <= position)
							ch = CHAR_N;
						while (m_ptr < m_cnt && m_hi[m_ptr] < position)
							m_ptr++;
						if (m_ptr < m_cnt && m_lo[m_ptr] <= position)
							ch = ch + LOWER_OFFSET;
						c = '{ch, 1'b0, 1'b0};
						run = {run, c};
						position++;
						column++;
						if (position == seq_length) begin
							c = '{CHAR_NL, 1'b0, 1'b1};
							run = {run, c};
							column = 0;
						end else if (column >= width) begin
							c = '{CHAR_NL, 1'b0, 1'b0};
							run = {run, c};
							column = 0;
						end
					end
					if (run.size() > 0)
						run[run.size() - 1].last_in_run = 1'b1;
					pending_chars = {pending_chars, run};
				end
			endcase
		endfunction

		function void check_result(logic [7:0] ch, logic last, logic send);
			fasta_out_t e;
			chars_seen++;
			if (pending_chars.size() == 0) begin
				$display("%0t unexpected character: expected none actual %h/%b/%b",
					$realtime, ch, last, send);
				errors++;
				return;
			end
			e = pending_chars.pop_front();
			if (ch !== e.fasta_char) begin
				$display("%0t fasta_char mismatch: expected %h actual %h",
					$realtime, e.fasta_char, ch);
				errors++;
			end
			if (last !== e.last_in_run) begin
				$display("%0t last_in_run mismatch: expected %b actual %b",
					$realtime, e.last_in_run, last);
				errors++;
			end
			if (send !== e.sequence_end) begin
				$display("%0t sequence_end mismatch: expected %b actual %b",
					$realtime, e.sequence_end, send);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tbf_in_if  in_ch();
	tbf_out_if out_ch();
	tbf_cfg_if cfg();

	twobit_dna_to_fasta_render_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	fasta_scoreboard sb = new();
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	int sequences_run;

	always #5 clk = ~clk;

	// Hold the run to a generous bound; a hang means a lost transaction.
	initial begin
		#1ms;
		$display("twobit_dna_to_fasta_render_core_tb NOT OK");
		$finish;
	end

	// Stall the output channel at random and check each accepted character.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.fasta_char, out_ch.last_in_run, out_ch.sequence_end);
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Push one input transaction; valid stays high into the next call unless it idles.
	task automatic send_item(opcode_t op, logic [31:0] bs, logic [31:0] bl, logic [7:0] pb);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.opcode       <= op;
		in_ch.block_start  <= bs;
		in_ch.block_length <= bl;
		in_ch.packed_byte  <= pb;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.note_input(op, bs, bl, pb);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted character has come out, plus
	// enough cycles for a byte that renders nothing to leave the back end.
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_chars.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Write one register; call only after drain.
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		sb.write_reg(idx, value);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// One sequence: start, ascending blocks, an occasional noise block, enough bytes plus spares.
	task automatic random_sequence();
		logic [31:0] len;
		logic [31:0] cur;
		int nb;
		int nbytes;
		len = $urandom_range(1, 24);
		drain();
		case ($urandom_range(9))
			0: write_reg(REG_LINE_WIDTH, 32'd65535);
			1: write_reg(REG_LINE_WIDTH, 32'd0);
			default: write_reg(REG_LINE_WIDTH, $urandom_range(1, 9));
		endcase
		write_reg(REG_SEQ_LENGTH, len);
		send_item(OP_START, $urandom, $urandom, 8'($urandom));
		cur = 0;
		nb = $urandom_range(0, 2);
		for (int i = 0; i < nb; i++) begin
			cur = cur + $urandom_range(0, 8);
			send_item(OP_LOAD_N, cur, $urandom_range(1, 6), 8'($urandom));
			cur = cur + 7;
		end
		cur = 0;
		nb = $urandom_range(0, 2);
		for (int i = 0; i < nb; i++) begin
			cur = cur + $urandom_range(0, 8);
			send_item(OP_LOAD_MASK, cur, $urandom_range(1, 6), 8'($urandom));
			cur = cur + 7;
		end
		// noise: a random block load, possibly unsorted or with huge fields
		if ($urandom_range(3) == 0)
			send_item(opcode_t'($urandom_range(1, 2)), $urandom, $urandom, 8'($urandom));
		nbytes = int'((len + 32'd3) / 32'd4) + int'($urandom_range(0, 1));
		for (int i = 0; i < nbytes; i++)
			send_item(OP_BYTE, $urandom, $urandom, 8'($urandom));
		sequences_run++;
	endtask

	initial begin
		in_ch.valid        <= 1'b0;
		in_ch.opcode       <= OP_START;
		in_ch.block_start  <= '0;
		in_ch.block_length <= '0;
		in_ch.packed_byte  <= '0;
		cfg.valid          <= 1'b0;
		cfg.index          <= REG_LINE_WIDTH;
		cfg.data           <= '0;
		send_idle_pct = 13;
		recv_idle_pct = 46;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset length of zero drops every nucleotide.
		send_item(OP_BYTE, '0, '0, 8'hFF);
		drain();
		write_reg(REG_LINE_WIDTH, 32'd4);
		write_reg(REG_SEQ_LENGTH, 32'd10);
		send_item(OP_START, '1, '1, 8'h00);
		send_item(OP_LOAD_N, 32'd2, 32'd3, 8'h00);
		send_item(OP_LOAD_N, 32'd20, 32'd0, 8'h00);      // zero length, ignored
		send_item(OP_LOAD_MASK, 32'd0, 32'd2, 8'h00);
		send_item(OP_LOAD_MASK, 32'd4, 32'd1, 8'h00);
		send_item(OP_BYTE, '0, '0, 8'h00);
		send_item(OP_BYTE, '0, '0, 8'hFF);
		send_item(OP_BYTE, '0, '0, 8'h1B);                // sequence ends mid byte
		send_item(OP_BYTE, '0, '0, 8'hE4);                // entirely dropped
		drain();
		// Line width zero, longest sequence, saturating and unsorted blocks.
		write_reg(REG_LINE_WIDTH, 32'd0);
		write_reg(REG_SEQ_LENGTH, 32'hFFFF_FFFF);
		send_item(OP_START, '0, '0, 8'h00);
		send_item(OP_LOAD_MASK, 32'd10, 32'd5, 8'h00);
		send_item(OP_LOAD_MASK, 32'd2, 32'd2, 8'h00);
		send_item(OP_LOAD_N, 32'hFFFF_FF00, 32'hFFFF_FFFF, 8'h00);
		for (int i = 0; i < 4; i++)
			send_item(OP_BYTE, '0, '0, 8'(8'h6C ^ (i * 8'h55)));
		drain();
		// Full table: loads past capacity are ignored.
		write_reg(REG_LINE_WIDTH, 32'd65535);
		write_reg(REG_SEQ_LENGTH, 32'd12);
		send_item(OP_START, '0, '0, 8'h00);
		for (int i = 0; i < MAX_N_BLOCKS + 1; i++)
			send_item(OP_LOAD_N, 32'(i * 2), 32'd1, 8'h00);
		for (int i = 0; i < 2; i++)
			send_item(OP_BYTE, '0, '0, 8'($urandom));
		drain();   // sender pauses until every character has come

		// Random sequences through three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 46 : 0;
			recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 13 : 0;
			random_sequence();
		end
		drain();

		$display("Ran %0d random sequences, %0d input transactions, %0d characters checked,",
			sequences_run, items_sent, sb.chars_seen);
		$display("covering N and mask blocks, line widths 0..65535 and dropped nucleotides.");
		if (sb.errors == 0 && sb.pending_chars.size() == 0)
			$display("twobit_dna_to_fasta_render_core_tb OK");
		else
			$display("twobit_dna_to_fasta_render_core_tb NOT OK");
		$finish;
	end

endmodule
